// ===== hdl/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg
// Shared opcodes, fault codes, command codes and the control and status
// bundles that pass between the stack machine controller and datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

	// Item commands.
	localparam logic CMD_EXEC    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Instruction opcodes.
	localparam logic [5:0] OP_IMM   = 6'd0;
	localparam logic [5:0] OP_LEA   = 6'd1;
	localparam logic [5:0] OP_JMP   = 6'd2;
	localparam logic [5:0] OP_JZ    = 6'd3;
	localparam logic [5:0] OP_JNZ   = 6'd4;
	localparam logic [5:0] OP_CALL  = 6'd5;
	localparam logic [5:0] OP_NVAR  = 6'd6;
	localparam logic [5:0] OP_DARG  = 6'd7;
	localparam logic [5:0] OP_RET   = 6'd8;
	localparam logic [5:0] OP_LI    = 6'd9;
	localparam logic [5:0] OP_LC    = 6'd10;
	localparam logic [5:0] OP_SI    = 6'd11;
	localparam logic [5:0] OP_SC    = 6'd12;
	localparam logic [5:0] OP_PUSH  = 6'd13;
	localparam logic [5:0] OP_OR    = 6'd14;
	localparam logic [5:0] OP_XOR   = 6'd15;
	localparam logic [5:0] OP_AND   = 6'd16;
	localparam logic [5:0] OP_EQ    = 6'd17;
	localparam logic [5:0] OP_NE    = 6'd18;
	localparam logic [5:0] OP_LT    = 6'd19;
	localparam logic [5:0] OP_GT    = 6'd20;
	localparam logic [5:0] OP_LE    = 6'd21;
	localparam logic [5:0] OP_GE    = 6'd22;
	localparam logic [5:0] OP_SHL   = 6'd23;
	localparam logic [5:0] OP_SHR   = 6'd24;
	localparam logic [5:0] OP_ADD   = 6'd25;
	localparam logic [5:0] OP_SUB   = 6'd26;
	localparam logic [5:0] OP_MUL   = 6'd27;
	localparam logic [5:0] OP_DIV   = 6'd28;
	localparam logic [5:0] OP_MOD   = 6'd29;
	localparam logic [5:0] OP_HOST_FIRST = 6'd30;
	localparam logic [5:0] OP_HOST_LAST  = 6'd37;
	localparam logic [5:0] OP_EXIT  = 6'd38;

	// Fault codes.
	localparam logic [2:0] FLT_NONE   = 3'd0;
	localparam logic [2:0] FLT_OPCODE = 3'd1;
	localparam logic [2:0] FLT_ADDR   = 3'd2;
	localparam logic [2:0] FLT_DIV0   = 3'd3;
	localparam logic [2:0] FLT_HOST   = 3'd4;

	// Multiply and divide unit operations.
	typedef enum logic [1:0] {
		UOP_MUL = 2'd0,
		UOP_DIV = 2'd1,
		UOP_MOD = 2'd2
	} svm_uop_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic rd_en;
		logic rd_second;
		logic unit_start;
		logic commit;
		logic clr_we;
	} svm_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_rdb;
		logic need_unit;
		logic unit_done;
		logic clr_last;
		logic out_free;
	} svm_sts_t;

endpackage

// ===== hdl/svm_muldiv.sv =====
// ----------------------------------------------------------------------------
// svm_muldiv
// Shared multiply and divide unit. Multiply uses one 32x32 multiplier for
// the partial products; signed divide and modulo use a radix-2 restoring loop.
// ----------------------------------------------------------------------------
module svm_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  svm_pkg::svm_uop_t uop,
	input  logic [63:0]      lhs,
	input  logic [63:0]      rhs,
	output logic             done,
	output logic [63:0]      result
);

	logic              busy_q;
	logic [6:0]        cnt_q;
	svm_pkg::svm_uop_t uop_q;
	logic              neg_q;
	logic [63:0]       a_q;
	logic [63:0]       b_q;
	logic [63:0]       rem_q;
	logic [63:0]       prod_q;
	logic [63:0]       sum_q;
	logic [63:0]       res_q;
	logic              done_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [64:0] rem_sh;
	logic        rem_ge;
	logic [63:0] lhs_mag;
	logic [63:0] rhs_mag;

	// Operand selection for the shared 32x32 multiplier.
	always_comb begin
		mul_a = (cnt_q == 7'd2) ? a_q[63:32] : a_q[31:0];
		mul_b = (cnt_q == 7'd1) ? b_q[63:32] : b_q[31:0];
		mul_p = {32'b0, mul_a} * {32'b0, mul_b};
	end

	// One restoring divide step.
	always_comb begin
		rem_sh  = {rem_q, a_q[63]};
		rem_ge  = rem_sh >= {1'b0, b_q};
		lhs_mag = lhs[63] ? (64'd0 - lhs) : lhs;
		rhs_mag = rhs[63] ? (64'd0 - rhs) : rhs;
	end

	// Sequencer and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if ((uop_q == svm_pkg::UOP_MUL && cnt_q == 7'd3) || cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			uop_q <= uop;
			rem_q <= '0;
			sum_q <= '0;
			if (uop == svm_pkg::UOP_MUL) begin
				a_q   <= lhs;
				b_q   <= rhs;
				neg_q <= 1'b0;
			end else begin
				a_q   <= lhs_mag;
				b_q   <= rhs_mag;
				neg_q <= (uop == svm_pkg::UOP_DIV) ? (lhs[63] ^ rhs[63]) : lhs[63];
			end
		end else if (busy_q) begin
			if (uop_q == svm_pkg::UOP_MUL) begin
				prod_q <= mul_p;
				case (cnt_q)
					7'd1: begin
						sum_q <= prod_q;
					end
					7'd2: begin
						sum_q <= sum_q + {prod_q[31:0], 32'b0};
					end
					7'd3: begin
						res_q <= sum_q + {prod_q[31:0], 32'b0};
					end
					default: begin
					end
				endcase
			end else if (cnt_q == 7'd64) begin
				if (uop_q == svm_pkg::UOP_DIV) begin
					res_q <= neg_q ? (64'd0 - a_q) : a_q;
				end else begin
					res_q <= neg_q ? (64'd0 - rem_q) : rem_q;
				end
			end else begin
				// The remainder stays below the divisor, so 64 bits hold it.
				rem_q <= rem_ge ? 64'(rem_sh - {1'b0, b_q}) : rem_sh[63:0];
				a_q   <= {a_q[62:0], rem_ge};
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== hdl/svm_dpath.sv =====
// ----------------------------------------------------------------------------
// svm_dpath
// Datapath of the stack machine: architectural registers, data and stack
// memory with its clearing sweep, instruction evaluation and the result word.
// ----------------------------------------------------------------------------
module svm_dpath #(
	parameter int MEM_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [16:0]         cfg_wdata,
	input  logic                cmd,
	input  logic [5:0]          opcode,
	input  logic [63:0]         operand,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [63:0]         acc,
	output logic [15:0]         next_pc,
	output logic [16:0]         stack_ptr_out,
	output logic                halted,
	output logic [63:0]         exit_value,
	output logic [2:0]          fault,
	input  svm_pkg::svm_ctl_t   ctl,
	output svm_pkg::svm_sts_t   sts
);

	localparam int DEPTH = MEM_BYTES / 8;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [63:0] WORD_LAST = 64'(MEM_BYTES - 8);
	localparam logic [63:0] BYTE_END  = 64'(MEM_BYTES);

	function automatic logic word_ok(input logic [63:0] a);
		return (a[2:0] == 3'b000) && (a <= WORD_LAST);
	endfunction

	// Item, configuration and architectural registers.
	logic        cmd_q;
	logic [5:0]  op_q;
	logic [63:0] imm_q;
	logic [16:0] stack_top_q;
	logic [63:0] acc_q;
	logic [15:0] pc_q;
	logic [16:0] sp_q;
	logic [16:0] bp_q;
	logic        halt_q;
	logic [2:0]  flt_q;
	logic [63:0] exit_q;
	logic        out_valid_q;

	// Memory and read data.
	logic [63:0]      mem [DEPTH];
	logic [63:0]      rdata_q;
	logic [63:0]      ra_q;
	logic [IDX_W-1:0] clr_cnt_q;

	logic [63:0] sp64;
	logic [63:0] bp64;
	logic [63:0] spm8;
	logic [63:0] bpp8;
	logic [63:0] addr_a;
	logic [63:0] addr_b;
	logic [63:0] raddr;
	logic [63:0] word_a;
	logic [63:0] word_b;
	logic        exec_live;
	logic        sp_ok;
	logic        is_binop;

	logic              unit_done;
	logic [63:0]       unit_res;
	svm_pkg::svm_uop_t unit_op;

	logic [63:0] alu;
	logic [7:0]  ld_byte;
	logic [5:0]  byte_sh;
	logic [63:0] t_acc;
	logic [63:0] t_sp;
	logic [63:0] t_bp;
	logic [15:0] t_pc;
	logic [2:0]  f;
	logic        t_exit_ok;
	logic        wr_req;
	logic [63:0] waddr;
	logic [63:0] wval;
	logic        mem_we;
	logic [IDX_W-1:0] widx;
	logic [63:0] wdata;

	// Common address arithmetic, done in 64 bits as the wrap rules require.
	always_comb begin
		sp64     = {47'b0, sp_q};
		bp64     = {47'b0, bp_q};
		spm8     = sp64 - 64'd8;
		bpp8     = bp64 + 64'd8;
		sp_ok    = word_ok(sp64);
		exec_live = (cmd_q == svm_pkg::CMD_EXEC) && !halt_q;
		is_binop = (op_q >= svm_pkg::OP_OR) && (op_q <= svm_pkg::OP_MOD);
	end

	// Read address selection for the first and second memory reads.
	always_comb begin
		case (op_q)
			svm_pkg::OP_RET: addr_a = bp64;
			svm_pkg::OP_LI,
			svm_pkg::OP_LC: addr_a = acc_q;
			default: addr_a = sp64;
		endcase
		addr_b = (op_q == svm_pkg::OP_RET) ? bpp8 : rdata_q;
		raddr  = ctl.rd_second ? addr_b : addr_a;
		sts.need_rdb = exec_live && ((op_q == svm_pkg::OP_RET) || (op_q == svm_pkg::OP_SC));
		word_a = sts.need_rdb ? ra_q : rdata_q;
		word_b = rdata_q;
	end

	// Multiply and divide unit.
	always_comb begin
		case (op_q)
			svm_pkg::OP_DIV: unit_op = svm_pkg::UOP_DIV;
			svm_pkg::OP_MOD: unit_op = svm_pkg::UOP_MOD;
			default: unit_op = svm_pkg::UOP_MUL;
		endcase
		sts.need_unit = exec_live && sp_ok && ((op_q == svm_pkg::OP_MUL) ||
			(((op_q == svm_pkg::OP_DIV) || (op_q == svm_pkg::OP_MOD)) && (acc_q != 64'd0)));
		sts.unit_done = unit_done;
		sts.clr_last  = (clr_cnt_q == IDX_W'(DEPTH - 1));
		sts.out_free  = !out_valid_q || out_ready;
	end

	svm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.unit_start),
		.uop    (unit_op),
		.lhs    (word_a),
		.rhs    (acc_q),
		.done   (unit_done),
		.result (unit_res)
	);

	// Binary operations on the popped word and the accumulator.
	always_comb begin
		case (op_q)
			svm_pkg::OP_OR:  alu = word_a | acc_q;
			svm_pkg::OP_XOR: alu = word_a ^ acc_q;
			svm_pkg::OP_AND: alu = word_a & acc_q;
			svm_pkg::OP_EQ:  alu = {63'b0, word_a == acc_q};
			svm_pkg::OP_NE:  alu = {63'b0, word_a != acc_q};
			svm_pkg::OP_LT:  alu = {63'b0, $signed(word_a) < $signed(acc_q)};
			svm_pkg::OP_GT:  alu = {63'b0, $signed(acc_q) < $signed(word_a)};
			svm_pkg::OP_LE:  alu = {63'b0, !($signed(acc_q) < $signed(word_a))};
			svm_pkg::OP_GE:  alu = {63'b0, !($signed(word_a) < $signed(acc_q))};
			svm_pkg::OP_SHL: alu = (|acc_q[63:6]) ? 64'd0 : (word_a << acc_q[5:0]);
			svm_pkg::OP_SHR: alu = (|acc_q[63:6]) ? {64{word_a[63]}} :
				64'($signed(word_a) >>> acc_q[5:0]);
			svm_pkg::OP_ADD: alu = word_a + acc_q;
			svm_pkg::OP_SUB: alu = word_a - acc_q;
			default:         alu = unit_res;
		endcase
	end

	// Instruction evaluation: tentative next state, fault and memory write.
	always_comb begin
		t_acc     = acc_q;
		t_pc      = pc_q;
		t_sp      = sp64;
		t_bp      = bp64;
		f         = svm_pkg::FLT_NONE;
		t_exit_ok = 1'b0;
		wr_req    = 1'b0;
		waddr     = spm8;
		wval      = acc_q;
		byte_sh   = {acc_q[2:0], 3'b000};
		ld_byte   = 8'(word_a >> byte_sh);
		case (op_q)
			svm_pkg::OP_IMM: begin
				t_acc = imm_q;
				t_pc  = pc_q + 16'd16;
			end
			svm_pkg::OP_LEA: begin
				t_acc = bp64 + (imm_q << 3);
				t_pc  = pc_q + 16'd16;
			end
			svm_pkg::OP_JMP: begin
				t_pc = imm_q[15:0];
			end
			svm_pkg::OP_JZ: begin
				t_pc = (acc_q != 64'd0) ? (pc_q + 16'd16) : imm_q[15:0];
			end
			svm_pkg::OP_JNZ: begin
				t_pc = (acc_q != 64'd0) ? imm_q[15:0] : (pc_q + 16'd16);
			end
			svm_pkg::OP_CALL: begin
				t_sp   = spm8;
				wr_req = 1'b1;
				wval   = {48'b0, pc_q + 16'd16};
				if (!word_ok(spm8)) f = svm_pkg::FLT_ADDR;
				t_pc   = imm_q[15:0];
			end
			svm_pkg::OP_NVAR: begin
				wr_req = 1'b1;
				wval   = bp64;
				if (!word_ok(spm8)) f = svm_pkg::FLT_ADDR;
				t_bp   = spm8;
				t_sp   = spm8 - (imm_q << 3);
				t_pc   = pc_q + 16'd16;
			end
			svm_pkg::OP_DARG: begin
				t_sp = sp64 + (imm_q << 3);
				t_pc = pc_q + 16'd16;
			end
			svm_pkg::OP_RET: begin
				if (!word_ok(bp64) || !word_ok(bpp8)) f = svm_pkg::FLT_ADDR;
				t_bp = word_a;
				t_pc = word_b[15:0];
				t_sp = bp64 + 64'd16;
			end
			svm_pkg::OP_LI: begin
				if (!word_ok(acc_q)) f = svm_pkg::FLT_ADDR;
				t_acc = word_a;
				t_pc  = pc_q + 16'd8;
			end
			svm_pkg::OP_LC: begin
				if (acc_q >= BYTE_END) f = svm_pkg::FLT_ADDR;
				t_acc = {{56{ld_byte[7]}}, ld_byte};
				t_pc  = pc_q + 16'd8;
			end
			svm_pkg::OP_SI: begin
				t_sp   = sp64 + 64'd8;
				wr_req = 1'b1;
				waddr  = word_a;
				wval   = acc_q;
				if (!sp_ok || !word_ok(word_a)) f = svm_pkg::FLT_ADDR;
				t_pc   = pc_q + 16'd8;
			end
			svm_pkg::OP_SC: begin
				t_sp    = sp64 + 64'd8;
				wr_req  = 1'b1;
				waddr   = word_a;
				byte_sh = {word_a[2:0], 3'b000};
				wval    = (word_b & ~(64'hFF << byte_sh)) | ({56'b0, acc_q[7:0]} << byte_sh);
				if (!sp_ok || (word_a >= BYTE_END)) f = svm_pkg::FLT_ADDR;
				t_pc    = pc_q + 16'd8;
			end
			svm_pkg::OP_PUSH: begin
				t_sp   = spm8;
				wr_req = 1'b1;
				if (!word_ok(spm8)) f = svm_pkg::FLT_ADDR;
				t_pc   = pc_q + 16'd8;
			end
			svm_pkg::OP_EXIT: begin
				if (!sp_ok) f = svm_pkg::FLT_ADDR;
				else t_exit_ok = 1'b1;
			end
			default: begin
				if (is_binop) begin
					t_sp  = sp64 + 64'd8;
					t_acc = alu;
					t_pc  = pc_q + 16'd8;
					if (!sp_ok) begin
						f = svm_pkg::FLT_ADDR;
					end else if (((op_q == svm_pkg::OP_DIV) || (op_q == svm_pkg::OP_MOD))
							&& (acc_q == 64'd0)) begin
						f = svm_pkg::FLT_DIV0;
					end
				end else if ((op_q >= svm_pkg::OP_HOST_FIRST) &&
						(op_q <= svm_pkg::OP_HOST_LAST)) begin
					f = svm_pkg::FLT_HOST;
				end else begin
					f = svm_pkg::FLT_OPCODE;
				end
			end
		endcase
	end

	// Memory write port, shared by the clearing sweep and stores.
	always_comb begin
		mem_we = ctl.clr_we || (ctl.commit && exec_live && wr_req &&
			(f == svm_pkg::FLT_NONE));
		widx   = ctl.clr_we ? clr_cnt_q : waddr[IDX_W+2:3];
		wdata  = ctl.clr_we ? 64'd0 : wval;
	end

	// Data and stack memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) mem[widx] <= wdata;
		if (ctl.rd_en) rdata_q <= mem[raddr[IDX_W+2:3]];
		if (ctl.rd_second) ra_q <= rdata_q;
	end

	// Clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr_we) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q <= cmd;
			op_q  <= opcode;
			imm_q <= operand;
		end
	end

	// Architectural state; it doubles as the result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_top_q <= 17'h10000;
			acc_q       <= '0;
			pc_q        <= '0;
			sp_q        <= 17'h10000;
			bp_q        <= 17'h10000;
			halt_q      <= 1'b0;
			flt_q       <= svm_pkg::FLT_NONE;
			exit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) stack_top_q <= cfg_wdata;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
				if (cmd_q == svm_pkg::CMD_RESTART) begin
					pc_q   <= imm_q[15:0];
					sp_q   <= stack_top_q;
					bp_q   <= stack_top_q;
					halt_q <= 1'b0;
					flt_q  <= svm_pkg::FLT_NONE;
					exit_q <= '0;
				end else if (!halt_q) begin
					if (f != svm_pkg::FLT_NONE) begin
						halt_q <= 1'b1;
						flt_q  <= f;
					end else if (t_exit_ok) begin
						halt_q <= 1'b1;
						exit_q <= word_a;
					end else begin
						acc_q <= t_acc;
						pc_q  <= t_pc;
						sp_q  <= t_sp[16:0];
						bp_q  <= t_bp[16:0];
					end
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign acc           = acc_q;
	assign next_pc       = pc_q;
	assign stack_ptr_out = sp_q;
	assign halted        = halt_q;
	assign exit_value    = exit_q;
	assign fault         = flt_q;

endmodule

// ===== hdl/svm_ctrl.sv =====
// ----------------------------------------------------------------------------
// svm_ctrl
// Controller of the stack machine: memory clearing after reset, the read
// sequence of each word, the wait on the multiply and divide unit, commit.
// ----------------------------------------------------------------------------
module svm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  svm_pkg::svm_sts_t sts,
	output svm_pkg::svm_ctl_t ctl
);

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_RDA  = 7'b0000100,
		S_RDB  = 7'b0001000,
		S_EXE  = 7'b0010000,
		S_UNIT = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_CLR: begin
				ctl.clr_we = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				ctl.rd_en = 1'b1;
				state_d = sts.need_rdb ? S_RDB : S_EXE;
			end
			S_RDB: begin
				ctl.rd_en     = 1'b1;
				ctl.rd_second = 1'b1;
				state_d = S_EXE;
			end
			S_EXE: begin
				if (sts.need_unit) begin
					ctl.unit_start = 1'b1;
					state_d = S_UNIT;
				end else if (sts.out_free) begin
					ctl.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_UNIT: begin
				if (sts.unit_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// Only one word is in flight at a time.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while another is in flight");

	// Each word commits once.
	a_single_commit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> !ctl.commit)
		else $error("commit on two consecutive cycles");

	// The unit answers only while it is awaited.
	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.unit_done |-> state_q == S_UNIT)
		else $error("unit finished outside of a wait");
`endif

endmodule

// ===== hdl/stack_accumulator_vm_core_top.sv =====
// ----------------------------------------------------------------------------
// stack_accumulator_vm_core_top
// Execution core of an accumulator and stack virtual machine. Each input
// word executes one instruction or restarts at a code address; each gives
// one result word with the machine state after it.
//
//   port group   direction  handshake            payload
//   cfg          in         cfg_we               cfg_wdata (stack top)
//   in           in         in_valid/in_ready    cmd, opcode, operand
//   out          out        out_valid/out_ready  acc, next_pc, stack_ptr_out,
//                                                halted, exit_value, fault
//
// Most words pass from acceptance to result through one memory read,
// then evaluation and commit. Return and byte store add a second read
// of the data memory, which has one read port. Multiply also waits on
// a shared 32x32 multiplier; divide and modulo wait on a radix-2 loop.
// After reset the memory is cleared, word by word, before in_ready
// rises. A result waiting on out_ready holds the commit of the next
// word but not its acceptance.
// ----------------------------------------------------------------------------
module stack_accumulator_vm_core_top #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [5:0]  opcode,
	input  logic [63:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] acc,
	output logic [15:0] next_pc,
	output logic [16:0] stack_ptr_out,
	output logic        halted,
	output logic [63:0] exit_value,
	output logic [2:0]  fault
);

	svm_pkg::svm_ctl_t ctl;
	svm_pkg::svm_sts_t sts;

	// Sequencing.
	svm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Registers, memory and evaluation.
	svm_dpath #(
		.MEM_BYTES (MEM_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.opcode        (opcode),
		.operand       (operand),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.acc           (acc),
		.next_pc       (next_pc),
		.stack_ptr_out (stack_ptr_out),
		.halted        (halted),
		.exit_value    (exit_value),
		.fault         (fault),
		.ctl           (ctl),
		.sts           (sts)
	);

endmodule
